FILE: sv/led_blink_pattern_driver_top_macros.svh
// Assertion macros for the LED blink pattern driver checker.
`ifndef LED_BLINK_PATTERN_DRIVER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_DRIVER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LBPD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbpd check failed: lbl");

// next-cycle implication
`define LBPD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbpd check failed: lbl");

`endif

FILE: sv/lbpd_pkg.sv
// Types, constants and interval ROM shared by the LED blink pattern driver.
package lbpd_pkg;

   localparam int SENSOR_WIDTH    = 10;
   localparam int TIME_WIDTH      = 32;
   localparam int LEVEL_WIDTH     = 8;
   localparam int COEF_WIDTH      = 15;
   localparam int PATTERN_WIDTH   = 3;
   localparam int STEP_WIDTH      = 3;
   localparam int INTERVAL_WIDTH  = 10;
   localparam int PATTERN_COUNT   = 7;
   localparam int PATTERN_ROWS    = 8;
   localparam int STEPS           = 6;
   localparam int PROD_WIDTH      = SENSOR_WIDTH + COEF_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = COEF_WIDTH;

   // round(x / 100): x + 50, then multiply by 2^19 / 100 rounded up
   localparam int ROUND_BIAS  = 50;
   localparam int SAT_PRODUCT = 25550;
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int DIV_WIDTH   = 15;
   localparam int RECIP_WIDTH = 13;

   localparam logic [COEF_WIDTH-1:0]  COEF_RESET      = COEF_WIDTH'(25);
   localparam logic [LEVEL_WIDTH-1:0] ON_LEVEL_RESET  = LEVEL_WIDTH'(255);
   localparam logic [LEVEL_WIDTH-1:0] OFF_LEVEL_RESET = LEVEL_WIDTH'(0);
   localparam logic [STEP_WIDTH-1:0]  LAST_STEP       = STEP_WIDTH'(STEPS - 1);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF      = 2'd0,
      CSR_ON_LEVEL  = 2'd1,
      CSR_OFF_LEVEL = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACT_POLL   = 1'b0,
      ACT_SELECT = 1'b1
   } action_type;

   typedef struct packed {
      logic                     action;
      logic [PATTERN_WIDTH-1:0] pattern;
      logic                     normal_mode;
      logic [SENSOR_WIDTH-1:0]  sensor_level;
      logic [TIME_WIDTH-1:0]    now_ms;
   } req_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] led_level;
      logic                   level_changed;
   } rsp_type;

   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_ROM [0:PATTERN_ROWS-1][0:STEPS-1] = '{
      '{10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800},
      '{10'd200, 10'd0,   10'd0,   10'd0,   10'd0,   10'd800},
      '{10'd120, 10'd140, 10'd240, 10'd0,   10'd0,   10'd800},
      '{10'd120, 10'd140, 10'd140, 10'd140, 10'd240, 10'd800},
      '{10'd800, 10'd0,   10'd0,   10'd0,   10'd0,   10'd200},
      '{10'd400, 10'd100, 10'd400, 10'd0,   10'd0,   10'd800},
      '{10'd400, 10'd100, 10'd400, 10'd100, 10'd400, 10'd800},
      '{10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0}
   };

   function automatic logic [INTERVAL_WIDTH-1:0] step_interval(
      input logic [PATTERN_WIDTH-1:0] row,
      input logic [STEP_WIDTH-1:0]    step
   );
      logic [INTERVAL_WIDTH-1:0] value;
      value = '0;
      if (step <= LAST_STEP) begin
         value = INTERVAL_ROM[row][step];
      end
      return value;
   endfunction

endpackage

FILE: sv/lbpd_scale.sv
// Normal-mode brightness: rounded product divided by 100, saturated at full scale.
module lbpd_scale (
   input  logic [lbpd_pkg::PROD_WIDTH-1:0]  product,
   output logic [lbpd_pkg::LEVEL_WIDTH-1:0] level
);
   import lbpd_pkg::*;

   localparam int QUOT_WIDTH = DIV_WIDTH + RECIP_WIDTH;

   logic                  saturate;
   logic [DIV_WIDTH-1:0]  biased;
   logic [QUOT_WIDTH-1:0] scaled;

   // below the saturation point product + 50 stays under 25600
   assign saturate = product >= PROD_WIDTH'(SAT_PRODUCT);
   assign biased   = product[DIV_WIDTH-1:0] + DIV_WIDTH'(ROUND_BIAS);
   assign scaled   = QUOT_WIDTH'(biased) * QUOT_WIDTH'(RECIP_100);
   assign level    = saturate ? '1 : scaled[RECIP_SHIFT +: LEVEL_WIDTH];

endmodule

FILE: sv/led_blink_pattern_driver_top.sv
// Top level of the LED blink pattern driver: request stage, pattern engine, response register.
// A request is held in the request register, then its response in the response register.
// Throughput: one request per cycle while responses are taken; the request register holds the
// sensor product, then the divide-by-100 and the blink step run against the held state.
// Reset (synchronous, active high) clears the LED state, selects the learn pattern
// pending start and loads the register defaults (gain 25, on 255, off 0).
module led_blink_pattern_driver_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lbpd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output lbpd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [lbpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lbpd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import lbpd_pkg::*;

   localparam logic [PATTERN_WIDTH:0] PATTERN_LIMIT =
      (PATTERN_COUNT > PATTERN_ROWS) ? (PATTERN_WIDTH+1)'(PATTERN_ROWS)
                                     : (PATTERN_WIDTH+1)'(PATTERN_COUNT);

   logic [COEF_WIDTH-1:0]    coef_ff;
   logic [LEVEL_WIDTH-1:0]   on_level_ff;
   logic [LEVEL_WIDTH-1:0]   off_level_ff;

   logic                     p_valid_ff, p_valid_in;
   req_type                  p_req_ff;
   logic [PROD_WIDTH-1:0]    p_prod_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [LEVEL_WIDTH-1:0]   applied_ff, applied_in;
   logic [PATTERN_WIDTH-1:0] row_ff, row_in;
   logic                     running_ff, running_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [TIME_WIDTH-1:0]    mark_ff, mark_in;

   logic                     req_fire, p_fire, out_ready;
   logic [LEVEL_WIDTH-1:0]   scaled_level, new_level;
   logic                     apply;
   logic                     pattern_ok;
   logic [TIME_WIDTH-1:0]    elapsed;
   logic [INTERVAL_WIDTH-1:0] interval;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign p_fire    = p_valid_ff && out_ready;
   assign req_ready = !p_valid_ff || out_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= COEF_RESET;
         on_level_ff  <= ON_LEVEL_RESET;
         off_level_ff <= OFF_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF:      coef_ff      <= csr_wdata[COEF_WIDTH-1:0];
            CSR_ON_LEVEL:  on_level_ff  <= csr_wdata[LEVEL_WIDTH-1:0];
            CSR_OFF_LEVEL: off_level_ff <= csr_wdata[LEVEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // request stage
   always_comb begin
      p_valid_in = p_valid_ff;
      if (req_fire) begin
         p_valid_in = 1'b1;
      end else if (p_fire) begin
         p_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_req_ff  <= req_data;
         p_prod_ff <= PROD_WIDTH'(req_data.sensor_level) * PROD_WIDTH'(coef_ff);
      end
   end

   lbpd_scale u_scale (
      .product (p_prod_ff),
      .level   (scaled_level)
   );

   // pattern engine
   assign pattern_ok = {1'b0, p_req_ff.pattern} < PATTERN_LIMIT;
   assign elapsed    = p_req_ff.now_ms - mark_ff;
   assign interval   = step_interval(row_ff, step_ff);

   always_comb begin
      row_in     = row_ff;
      running_in = running_ff;
      step_in    = step_ff;
      mark_in    = mark_ff;
      new_level  = applied_ff;
      apply      = 1'b0;
      if (p_req_ff.action == ACT_SELECT) begin
         if (pattern_ok) begin
            row_in     = p_req_ff.pattern;
            running_in = 1'b0;
         end
      end else if (p_req_ff.normal_mode) begin
         new_level = scaled_level;
         apply     = 1'b1;
      end else if (!running_ff) begin
         new_level  = on_level_ff;
         apply      = 1'b1;
         mark_in    = p_req_ff.now_ms;
         step_in    = '0;
         running_in = 1'b1;
      end else if (elapsed >= TIME_WIDTH'(interval)) begin
         // even steps end an on phase, odd steps an off phase
         new_level = step_ff[0] ? on_level_ff : off_level_ff;
         apply     = 1'b1;
         mark_in   = p_req_ff.now_ms;
         step_in   = (step_ff == LAST_STEP) ? '0 : step_ff + STEP_WIDTH'(1);
      end
      applied_in           = apply ? new_level : applied_ff;
      rsp_in.led_level     = applied_in;
      rsp_in.level_changed = apply && (new_level != applied_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         applied_ff <= '0;
         row_ff     <= '0;
         running_ff <= 1'b0;
         step_ff    <= '0;
         mark_ff    <= '0;
      end else if (p_fire) begin
         applied_ff <= applied_in;
         row_ff     <= row_in;
         running_ff <= running_in;
         step_ff    <= step_in;
         mark_ff    <= mark_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (p_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/lbpd_checker.sv
// Port-level checks for the LED blink pattern driver, bound to the top level.
`include "led_blink_pattern_driver_top_macros.svh"

module lbpd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lbpd_pkg::rsp_type rsp_data
);
   import lbpd_pkg::*;

   logic [1:0]             pending_ff, pending_in;
   logic [LEVEL_WIDTH-1:0] last_level_ff;
   logic                   req_xfer, rsp_xfer;
   logic                   level_moved;

   assign req_xfer    = req_valid && req_ready;
   assign rsp_xfer    = rsp_valid && rsp_ready;
   assign level_moved = rsp_data.led_level != last_level_ff;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_level_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_xfer) begin
            last_level_ff <= rsp_data.led_level;
         end
      end
   end

   `LBPD_ASSERT_NXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `LBPD_ASSERT_IMP(changed_flag, rsp_xfer, rsp_data.level_changed == level_moved)
   `LBPD_ASSERT_IMP(no_spurious_rsp, rsp_valid, pending_ff != 2'd0)
   `LBPD_ASSERT_IMP(ready_when_empty, pending_ff == 2'd0, req_ready)

endmodule

bind led_blink_pattern_driver_top lbpd_checker u_lbpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/tb_top.sv
// Testbench for the LED blink pattern driver: directed table, then checked random transfers.
`timescale 1ns / 100ps

module tb_top;
   import lbpd_pkg::*;

   localparam int unsigned BLINK_STEPS = 6;
   localparam int unsigned BLINK_PATTERNS = 7;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 250;
   localparam int unsigned RANDOM_PHASES = 5;

   localparam int unsigned BLINK_ROM [0:41] = '{
      800, 800, 800, 800, 800, 800,
      200,   0,   0,   0,   0, 800,
      120, 140, 240,   0,   0, 800,
      120, 140, 140, 140, 240, 800,
      800,   0,   0,   0,   0, 200,
      400, 100, 400,   0,   0, 800,
      400, 100, 400, 100, 400, 800
   };

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   // shadow of the block's registers and LED state
   int unsigned cfg_gain = 25;
   int unsigned cfg_on = 255;
   int unsigned cfg_off = 0;
   logic [7:0] led_now = '0;
   int unsigned blink_base = 0;
   int unsigned blink_step = 0;
   logic [31:0] blink_mark = '0;

   rsp_type led_expected [$];
   int errors = 0;
   int unsigned cycles = 0;
   int unsigned sent = 0;
   bit steady = 1'b0;

   led_blink_pattern_driver_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d transfers outstanding", $time, led_expected.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (led_expected.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual level %0d changed %0b",
                     $time, rsp_data.led_level, rsp_data.level_changed);
            errors++;
         end else begin
            exp_rsp = led_expected.pop_front();
            if (rsp_data.led_level !== exp_rsp.led_level) begin
               $display("%0t: led_level mismatch, expected %0d actual %0d",
                        $time, exp_rsp.led_level, rsp_data.led_level);
               errors++;
            end
            if (rsp_data.level_changed !== exp_rsp.level_changed) begin
               $display("%0t: level_changed mismatch, expected %0b actual %0b",
                        $time, exp_rsp.level_changed, rsp_data.level_changed);
               errors++;
            end
         end
      end
   end

   function automatic rsp_type led_after_item(input req_type r);
      rsp_type o;
      int unsigned lvl;
      int unsigned first;
      logic [31:0] elapsed;
      logic [7:0] target;
      logic apply;
      apply = 1'b0;
      target = '0;
      if (r.action == ACT_SELECT) begin
         if (r.pattern < BLINK_PATTERNS) blink_base = r.pattern * BLINK_STEPS;
      end else if (r.normal_mode) begin
         lvl = (r.sensor_level * cfg_gain + 50) / 100;
         apply = 1'b1;
         target = (lvl > 255) ? 8'd255 : 8'(lvl);
      end else if (blink_base % BLINK_STEPS == 0) begin
         apply = 1'b1;
         target = 8'(cfg_on);
         blink_mark = r.now_ms;
         blink_step = blink_base;
         blink_base = blink_base + 1;
      end else begin
         first = blink_base - 1;
         elapsed = r.now_ms - blink_mark;
         if (elapsed >= BLINK_ROM[blink_step]) begin
            blink_mark = r.now_ms;
            apply = 1'b1;
            target = (blink_step % 2 == 1) ? 8'(cfg_on) : 8'(cfg_off);
            blink_step = blink_step + 1;
            if (blink_step >= first + BLINK_STEPS || blink_step < first) blink_step = first;
         end
      end
      o.level_changed = apply && (target != led_now);
      if (apply) led_now = target;
      o.led_level = led_now;
      return o;
   endfunction

   task automatic send_req(input req_type item, input logic typed, input rsp_type want);
      rsp_type guess;
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      guess = led_after_item(item);
      led_expected.push_back(typed ? want : guess);
      sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (led_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_regs(input int unsigned gain, input int unsigned on,
                             input int unsigned off);
      csr_we <= 1'b1;
      csr_index <= CSR_COEF;
      csr_wdata <= CSR_DATA_WIDTH'(gain);
      @(posedge clock);
      csr_index <= CSR_ON_LEVEL;
      csr_wdata <= CSR_DATA_WIDTH'(on & 8'hFF);
      @(posedge clock);
      csr_index <= CSR_OFF_LEVEL;
      csr_wdata <= CSR_DATA_WIDTH'(off & 8'hFF);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_gain = gain & 15'h7FFF;
      cfg_on = on & 8'hFF;
      cfg_off = off & 8'hFF;
   endtask

   function automatic directed_row_type dir_row(input logic act, input logic [2:0] pat,
                                                input logic nrm, input logic [9:0] sen,
                                                input logic [31:0] t, input logic typed,
                                                input logic [7:0] led, input logic chg);
      directed_row_type d;
      d.item.action = act;
      d.item.pattern = pat;
      d.item.normal_mode = nrm;
      d.item.sensor_level = sen;
      d.item.now_ms = t;
      d.typed = typed;
      d.want.led_level = led;
      d.want.level_changed = chg;
      return d;
   endfunction

   function automatic req_type poll_item(input logic nrm, input logic [31:0] t);
      req_type r;
      r.action = ACT_POLL;
      r.pattern = 3'($urandom_range(7));
      r.normal_mode = nrm;
      r.sensor_level = 10'($urandom_range(1023));
      r.now_ms = t;
      return r;
   endfunction

   initial begin
      directed_row_type directed_set [$];
      req_type item;
      rsp_type none;
      logic [31:0] clk_ms;
      int unsigned gains [RANDOM_PHASES];
      int unsigned ons [RANDOM_PHASES];
      int unsigned offs [RANDOM_PHASES];
      int unsigned run_len;
      int unsigned k;

      gains = '{0, 25500, 32767, 100, 0};
      ons = '{0, 255, 1, 90, 0};
      offs = '{255, 0, 254, 90, 0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_COEF;
      csr_wdata = '0;
      none = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: gain 25, on 255, off 0
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b1, 10'd0, 32'd0, 1'b1, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b1, 10'd1023, 32'd0, 1'b1, 8'd255, 1'b1));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b1, 10'd2, 32'd0, 1'b1, 8'd1, 1'b1));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b1, 10'd1, 32'd0, 1'b1, 8'd0, 1'b1));
      directed_set.push_back(dir_row(ACT_SELECT, 3'd7, 1'b0, 10'd1023, 32'hFFFF_FFFF,
                                     1'b1, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_SELECT, 3'd0, 1'b1, 10'd0, 32'd0, 1'b1, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd100, 1'b1, 8'd255, 1'b1));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd899, 1'b1, 8'd255, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd900, 1'b1, 8'd0, 1'b1));
      directed_set.push_back(dir_row(ACT_SELECT, 3'd1, 1'b0, 10'd0, 32'd0, 1'b1, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'hFFFF_FF00,
                                     1'b1, 8'd255, 1'b1));
      // time wraps past zero, then zero intervals step once per poll
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd8, 1'b1, 8'd0, 1'b1));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd8, 1'b1, 8'd255, 1'b1));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd8, 1'b1, 8'd0, 1'b1));
      directed_set.push_back(dir_row(ACT_POLL, 3'd5, 1'b1, 10'd1023, 32'd8, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd8, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd8, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd807, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd808, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_SELECT, 3'd2, 1'b0, 10'd0, 32'd0, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd1000, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd1120, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_SELECT, 3'd6, 1'b1, 10'd0, 32'd0, 1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'hFFFF_FFFF,
                                     1'b0, 8'd0, 1'b0));
      directed_set.push_back(dir_row(ACT_POLL, 3'd0, 1'b0, 10'd0, 32'd399, 1'b0, 8'd0, 1'b0));

      foreach (directed_set[i]) send_req(directed_set[i].item, directed_set[i].typed,
                                         directed_set[i].want);
      drain();

      clk_ms = $urandom;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1)
            write_regs($urandom_range(25500), $urandom_range(255), $urandom_range(255));
         else
            write_regs(gains[p], ons[p], offs[p]);
         steady = (p == 2);
         while (sent < directed_set.size() + (p + 1) * PHASE_ITEMS) begin
            k = $urandom_range(99);
            if (k < 10) begin
               item = req_type'({$urandom, $urandom});
               send_req(item, 1'b0, none);
            end else if (k < 20) begin
               send_req(poll_item(1'b1, clk_ms), 1'b0, none);
            end else begin
               // pattern select followed by a run of polls
               item = poll_item(1'b0, clk_ms);
               item.action = ACT_SELECT;
               item.pattern = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6));
               send_req(item, 1'b0, none);
               if ($urandom_range(19) == 0) clk_ms = 32'hFFFF_FC00 + $urandom_range(1023);
               run_len = $urandom_range(30, 4);
               for (int j = 0; j < run_len; j++) begin
                  k = $urandom_range(99);
                  if (k < 25 && blink_base % BLINK_STEPS != 0)
                     clk_ms = blink_mark + BLINK_ROM[blink_step] - $urandom_range(1);
                  else if (k < 50)
                     clk_ms = clk_ms + $urandom_range(20);
                  else if (k < 80)
                     clk_ms = clk_ms + $urandom_range(400, 100);
                  else
                     clk_ms = clk_ms + $urandom_range(900, 400);
                  send_req(poll_item($urandom_range(99) < 8, clk_ms), 1'b0, none);
               end
            end
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
